// ----- hw/rtl/ipt_pkg.sv -----
// Shared types and constants for the indexed priority task table.
// Used by every module in hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package ipt_pkg;

   // Field widths of the request and response channels
   localparam int COMMAND_W   = 2;
   localparam int USER_ID_W   = 16;
   localparam int TASK_ID_W   = 10;
   localparam int PRIO_REQ_W  = 30;
   localparam int OWNER_W     = 16;

   // Default sizing of the table
   localparam int DEF_TASK_SLOTS    = 1024;
   localparam int DEF_USER_BITS     = 16;
   localparam int DEF_PRIORITY_BITS = 30;

   // Request command codes
   typedef enum logic [COMMAND_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_EDIT   = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_EXEC   = 2'd3
   } command_type;

   // Controls from the sequencer to the best-entry tracker
   typedef struct packed {
      logic clear;    // start of a new search
      logic sample;   // memory read data is a scanned entry
   } best_ctl_type;

endpackage

// ----- hw/rtl/indexed_priority_task_table_top.sv -----
// Indexed priority task table: add/edit/remove by task id, execute the top entry.
// Add and remove write the slot on acceptance; edit reads the slot, then writes it back if present.
// Execute scans every slot through the single read port, drains the last read, then
// retires the top entry and registers its response once the output register is free.
// After reset a clearing pass writes every slot invalid, with req_stall high.
// One request is in work at a time; a finished response waits in the output register.
`timescale 1ns / 1ps

module indexed_priority_task_table_top
   import ipt_pkg::*;
#(
   parameter int TASK_SLOTS    = DEF_TASK_SLOTS,
   parameter int USER_BITS     = DEF_USER_BITS,
   parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COMMAND_W-1:0]  req_command,
   input  logic [USER_ID_W-1:0]  req_user_id,
   input  logic [TASK_ID_W-1:0]  req_task_id,
   input  logic [PRIO_REQ_W-1:0] req_priority_req,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic [OWNER_W-1:0]    rsp_owner_user
);

   localparam int SLOT_W = $clog2(TASK_SLOTS);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_EDIT   = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [SLOT_W-1:0]        cnt_ff, cnt_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic [SLOT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [SLOT_W-1:0]        op_slot_ff, op_slot_in;
   logic [PRIORITY_BITS-1:0] op_prio_ff, op_prio_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [OWNER_W-1:0]       rsp_owner_ff, rsp_owner_in;

   logic                     accept;
   command_type              cmd;
   logic [31:0]              id_ext;
   logic                     id_ok;
   logic [SLOT_W-1:0]        req_slot;
   logic                     out_free;
   logic                     last_slot;

   logic                     wr_en;
   logic [SLOT_W-1:0]        wr_addr;
   logic                     wr_valid;
   logic [USER_BITS-1:0]     wr_user;
   logic [PRIORITY_BITS-1:0] wr_prio;
   logic [SLOT_W-1:0]        rd_addr;
   logic                     rd_valid;
   logic [USER_BITS-1:0]     rd_user;
   logic [PRIORITY_BITS-1:0] rd_prio;

   best_ctl_type             best_ctl;
   logic                     best_any;
   logic [USER_BITS-1:0]     best_user;
   logic [SLOT_W-1:0]        best_slot;
   logic [31:0]              best_user_ext;

   // Request decode
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign cmd       = command_type'(req_command);
   assign id_ext    = 32'(req_task_id);
   assign id_ok     = id_ext < 32'(TASK_SLOTS);
   assign req_slot  = id_ext[SLOT_W-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_slot = (cnt_ff == SLOT_W'(TASK_SLOTS - 1));
   assign best_user_ext = 32'(best_user);

   // Memory read address: scan counter or the addressed slot
   assign rd_addr = (state_ff == ST_SCAN) ? cnt_ff : req_slot;

   // Sequencer, memory write port and response register
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = cnt_ff;
      op_slot_in   = op_slot_ff;
      op_prio_in   = op_prio_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_owner_in = rsp_owner_ff;
      wr_en        = 1'b0;
      wr_addr      = req_slot;
      wr_valid     = 1'b0;
      wr_user      = USER_BITS'(req_user_id);
      wr_prio      = PRIORITY_BITS'(req_priority_req);
      best_ctl     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            cnt_in  = cnt_ff + 1'b1;
            if (last_slot) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_ADD: begin
                     wr_en    = id_ok;
                     wr_valid = 1'b1;
                  end
                  CMD_REMOVE: begin
                     wr_en = id_ok;
                  end
                  CMD_EDIT: begin
                     op_slot_in = req_slot;
                     op_prio_in = PRIORITY_BITS'(req_priority_req);
                     if (id_ok) begin
                        state_in = ST_EDIT;
                     end
                  end
                  CMD_EXEC: begin
                     best_ctl.clear = 1'b1;
                     cnt_in         = '0;
                     state_in       = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_EDIT: begin
            // Read data of the addressed slot is here; write back if present
            wr_en    = rd_valid;
            wr_addr  = op_slot_ff;
            wr_valid = 1'b1;
            wr_user  = rd_user;
            wr_prio  = op_prio_ff;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            best_ctl.sample = rd_pend_ff;
            rd_pend_in      = 1'b1;
            cnt_in          = cnt_ff + 1'b1;
            if (last_slot) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            best_ctl.sample = rd_pend_ff;
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               wr_en        = best_any;
               wr_addr      = best_slot;
               rsp_valid_in = 1'b1;
               rsp_found_in = best_any;
               rsp_owner_in = best_any ? best_user_ext[OWNER_W-1:0] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      op_slot_ff   <= op_slot_in;
      op_prio_ff   <= op_prio_in;
      rsp_found_ff <= rsp_found_in;
      rsp_owner_ff <= rsp_owner_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_owner_user = rsp_owner_ff;

   ipt_mem #(
      .TASK_SLOTS    (TASK_SLOTS),
      .USER_BITS     (USER_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_valid (wr_valid),
      .wr_user  (wr_user),
      .wr_prio  (wr_prio),
      .rd_addr  (rd_addr),
      .rd_valid (rd_valid),
      .rd_user  (rd_user),
      .rd_prio  (rd_prio)
   );

   ipt_best #(
      .TASK_SLOTS    (TASK_SLOTS),
      .USER_BITS     (USER_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_best (
      .clock     (clock),
      .reset     (reset),
      .ctl       (best_ctl),
      .ent_valid (rd_valid),
      .ent_user  (rd_user),
      .ent_prio  (rd_prio),
      .ent_slot  (rd_idx_ff),
      .best_any  (best_any),
      .best_user (best_user),
      .best_slot (best_slot)
   );

   // No table writes while an execute scan is reading the memory
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> !wr_en)
      else $error("table write during execute scan");

   // A not-found response carries a zero user
   a_empty_zero_user: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_owner_ff == '0))
      else $error("not-found response with nonzero user");

   // Requests are held off during the clearing pass after reset
   a_stall_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> req_stall)
      else $error("request accepted during clearing pass");

   // Finishing an execute always presents a response on the next cycle
   a_finish_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> rsp_valid_ff)
      else $error("execute finished without a response");

endmodule

// ----- hw/rtl/ipt_mem.sv -----
// Task table storage: one synchronous memory of {valid, user, priority}.
// One write port, one read port with registered read data. Uses ipt_pkg.
`timescale 1ns / 1ps

module ipt_mem
   import ipt_pkg::*;
#(
   parameter int TASK_SLOTS    = DEF_TASK_SLOTS,
   parameter int USER_BITS     = DEF_USER_BITS,
   parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
   localparam int SLOT_W       = $clog2(TASK_SLOTS)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [SLOT_W-1:0]        wr_addr,
   input  logic                     wr_valid,
   input  logic [USER_BITS-1:0]     wr_user,
   input  logic [PRIORITY_BITS-1:0] wr_prio,
   input  logic [SLOT_W-1:0]        rd_addr,
   output logic                     rd_valid,
   output logic [USER_BITS-1:0]     rd_user,
   output logic [PRIORITY_BITS-1:0] rd_prio
);

   localparam int ENTRY_W = 1 + USER_BITS + PRIORITY_BITS;

   logic [ENTRY_W-1:0] mem [TASK_SLOTS];
   logic [ENTRY_W-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_valid, wr_user, wr_prio};
      end
   end

   // Read port with registered read data
   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
   end

   assign rd_valid = rdata_ff[ENTRY_W-1];
   assign rd_user  = rdata_ff[PRIORITY_BITS +: USER_BITS];
   assign rd_prio  = rdata_ff[PRIORITY_BITS-1:0];

endmodule

// ----- hw/rtl/ipt_best.sv -----
// Running maximum over scanned table entries; ties go to the later slot.
// Fed one entry a cycle by the top-level sequencer. Uses ipt_pkg.
`timescale 1ns / 1ps

module ipt_best
   import ipt_pkg::*;
#(
   parameter int TASK_SLOTS    = DEF_TASK_SLOTS,
   parameter int USER_BITS     = DEF_USER_BITS,
   parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
   localparam int SLOT_W       = $clog2(TASK_SLOTS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  best_ctl_type             ctl,
   input  logic                     ent_valid,
   input  logic [USER_BITS-1:0]     ent_user,
   input  logic [PRIORITY_BITS-1:0] ent_prio,
   input  logic [SLOT_W-1:0]        ent_slot,
   output logic                     best_any,
   output logic [USER_BITS-1:0]     best_user,
   output logic [SLOT_W-1:0]        best_slot
);

   logic                     any_ff, any_in;
   logic [USER_BITS-1:0]     user_ff, user_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic                     take;

   // Scan runs upward, so >= hands a tie to the higher slot
   assign take = ctl.sample && ent_valid && (!any_ff || ent_prio >= prio_ff);

   always_comb begin
      any_in  = any_ff;
      user_in = user_ff;
      prio_in = prio_ff;
      slot_in = slot_ff;
      priority if (ctl.clear) begin
         any_in = 1'b0;
      end else if (take) begin
         any_in  = 1'b1;
         user_in = ent_user;
         prio_in = ent_prio;
         slot_in = ent_slot;
      end else begin
         // hold the current best
         any_in = any_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= 1'b0;
      end else begin
         any_ff <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      user_ff <= user_in;
      prio_ff <= prio_in;
      slot_ff <= slot_in;
   end

   assign best_any  = any_ff;
   assign best_user = user_ff;
   assign best_slot = slot_ff;

endmodule

// ----- dv/indexed_priority_task_table_top_test.sv -----
// Self-checking testbench for indexed_priority_task_table_top: directed and random requests.
// Mirrors the task table to predict each execute response; depends on ipt_pkg and the RTL.
`timescale 1ns / 1ps

module indexed_priority_task_table_top_test
   import ipt_pkg::*;
();

   localparam int SLOTS = DEF_TASK_SLOTS;
   localparam int RANDOM_ITEMS = 185;
   localparam int POOL_SPAN = 32;
   localparam logic [PRIO_REQ_W-1:0] PRIO_TOP = '1;
   localparam logic [OWNER_W-1:0] USER_TOP = '1;

   typedef struct packed {
      logic               found;
      logic [OWNER_W-1:0] owner;
   } exec_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   command_type           req_command = CMD_ADD;
   logic [USER_ID_W-1:0]  req_user_id = '0;
   logic [TASK_ID_W-1:0]  req_task_id = '0;
   logic [PRIO_REQ_W-1:0] req_priority_req = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_found;
   logic [OWNER_W-1:0]    rsp_owner_user;

   // Mirror of the task table
   bit                    slot_live  [SLOTS];
   logic [OWNER_W-1:0]    slot_owner [SLOTS];
   logic [PRIO_REQ_W-1:0] slot_prio  [SLOTS];

   exec_result_type pending_results[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   indexed_priority_task_table_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_user_id      (req_user_id),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_owner_user   (rsp_owner_user)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Pick the highest-priority live slot (ties to the higher id), retire it
   function automatic exec_result_type exec_top_entry();
      exec_result_type       res;
      bit                    any;
      int                    best;
      logic [PRIO_REQ_W-1:0] best_prio;
      res = '0;
      any = 1'b0;
      best = 0;
      best_prio = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (slot_live[s] && (!any || slot_prio[s] >= best_prio)) begin
            any = 1'b1;
            best_prio = slot_prio[s];
            best = s;
         end
      end
      if (any) begin
         slot_live[best] = 1'b0;
         res.found = 1'b1;
         res.owner = slot_owner[best];
      end
      return res;
   endfunction

   // Update the mirror for one accepted request; execute queues its response
   function automatic void apply_request(command_type cmd, logic [USER_ID_W-1:0] user,
                                         logic [TASK_ID_W-1:0] id,
                                         logic [PRIO_REQ_W-1:0] prio);
      case (cmd)
         CMD_ADD: begin
            slot_live[id] = 1'b1;
            slot_owner[id] = user;
            slot_prio[id] = prio;
         end
         CMD_EDIT: begin
            if (slot_live[id])
               slot_prio[id] = prio;
         end
         CMD_REMOVE: slot_live[id] = 1'b0;
         default: pending_results.push_back(exec_top_entry());
      endcase
   endfunction

   // Drive one request, with random lead-in gaps, and hold it until accepted
   task automatic send_request(input command_type cmd, input logic [USER_ID_W-1:0] user,
                               input logic [TASK_ID_W-1:0] id,
                               input logic [PRIO_REQ_W-1:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_user_id <= user;
      req_task_id <= id;
      req_priority_req <= prio;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      apply_request(cmd, user, id, prio);
   endtask

   // Stop sending until every queued response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_request(CMD_EXEC, USER_TOP, '1, PRIO_TOP);
      send_request(CMD_REMOVE, 16'h0, 10'd999, '0);
      send_request(CMD_EXEC, 16'h0, 10'd0, '0);
   endtask

   // Extremes of id, user and priority; equal priorities go to the higher id
   task automatic test_priority_and_ties();
      send_request(CMD_ADD, USER_TOP, 10'd0, '0);
      send_request(CMD_ADD, 16'h0, 10'd1023, PRIO_TOP);
      send_request(CMD_ADD, 16'h1234, 10'd512, PRIO_TOP);
      send_request(CMD_EXEC, 16'h0, 10'd0, '0);
      send_request(CMD_EXEC, 16'h0, 10'd0, '0);
      send_request(CMD_ADD, 16'h0001, 10'd3, '0);
      send_request(CMD_ADD, 16'h0002, 10'd2, '0);
      send_request(CMD_EXEC, 16'h0, 10'd0, '0);
      send_request(CMD_EXEC, 16'h0, 10'd0, '0);
      send_request(CMD_EXEC, 16'h0, 10'd0, '0);
   endtask

   // Overwrite by add, edit up and down, edit/remove of absent ids
   task automatic test_overwrite_edit_remove();
      send_request(CMD_ADD, 16'hAAAA, 10'd5, 30'd7);
      send_request(CMD_ADD, 16'h5555, 10'd5, 30'd3);
      send_request(CMD_EDIT, 16'hFFFF, 10'd700, PRIO_TOP);
      send_request(CMD_REMOVE, 16'h0, 10'd999, '0);
      send_request(CMD_ADD, 16'h0009, 10'd9, 30'd50);
      send_request(CMD_ADD, 16'h0008, 10'd8, 30'd40);
      send_request(CMD_EDIT, 16'h0, 10'd9, 30'd1);
      send_request(CMD_EDIT, 16'h0, 10'd5, 30'd45);
      send_request(CMD_EXEC, 16'h0, 10'd0, '0);
      send_request(CMD_REMOVE, 16'h0, 10'd8, '0);
      send_request(CMD_EXEC, 16'h0, 10'd0, '0);
      send_request(CMD_EXEC, 16'h0, 10'd0, '0);
   endtask

   // Mostly traffic on a small id window so edits, removes and ties hit live slots
   task automatic test_random_traffic(input int count);
      int                    pool_base;
      int                    pick;
      command_type           cmd;
      logic [TASK_ID_W-1:0]  id;
      logic [PRIO_REQ_W-1:0] prio;
      pool_base = $urandom_range(SLOTS - 1);
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 63)
            pool_base = $urandom_range(SLOTS - 1);
         pick = $urandom_range(99);
         if (pick < 40)
            cmd = CMD_ADD;
         else if (pick < 55)
            cmd = CMD_EDIT;
         else if (pick < 70)
            cmd = CMD_REMOVE;
         else
            cmd = CMD_EXEC;
         if ($urandom_range(99) < 75)
            id = TASK_ID_W'(pool_base + $urandom_range(POOL_SPAN - 1));
         else
            id = TASK_ID_W'($urandom());
         if ($urandom_range(99) < 30)
            prio = PRIO_REQ_W'($urandom_range(3));
         else
            prio = PRIO_REQ_W'($urandom());
         send_request(cmd, USER_ID_W'($urandom()), id, prio);
      end
   endtask

   // Fill a few slots, then hold off until the execute response has returned
   task automatic test_pause_until_drained();
      for (int n = 0; n < 4; n++)
         send_request(CMD_ADD, USER_ID_W'($urandom()), TASK_ID_W'($urandom()),
                      PRIO_REQ_W'($urandom()));
      send_request(CMD_EXEC, 16'h0, 10'd0, '0);
      wait_drained();
      send_request(CMD_EXEC, 16'h0, 10'd0, '0);
   endtask

   // Response side: random stall, compare each accepted response in order
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      exec_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: found=%0b owner_user=%h", rsp_found, rsp_owner_user);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_found);
               error_count++;
            end
            if (rsp_owner_user !== want.owner) begin
               $error("owner_user: expected %h, got %h", want.owner, rsp_owner_user);
               error_count++;
            end
         end
      end
   end

   // Main sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_priority_and_ties();
      test_overwrite_edit_remove();
      send_idle_pct = 33;
      rsp_stall_pct = 49;
      test_random_traffic(RANDOM_ITEMS);
      test_pause_until_drained();
      send_idle_pct = 49;
      rsp_stall_pct = 33;
      test_random_traffic(RANDOM_ITEMS);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_traffic(RANDOM_ITEMS);
      wait_drained();
      // catch any stray response after the last expected one
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog: several times the slowest legal run
   initial begin
      #(40_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
